>>> hdl/smbios_structure_table_matcher_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the SMBIOS structure table matcher
// Concurrent checks, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SMBIOS_STRUCTURE_TABLE_MATCHER_TOP_ASSERT_SVH
`define SMBIOS_STRUCTURE_TABLE_MATCHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMBIOS_STM_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMBIOS_STM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/smbios_stm_pkg.sv
// ---------------------------------------------------------------------------
// SMBIOS structure table matcher package
// Shared types, register indexes and helper functions.
// ---------------------------------------------------------------------------
package smbios_stm_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [7:0]  MinLen   = 8'd4;
  localparam logic [15:0] Max16    = 16'hFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReportAll   = 3'd0,
    CfgTypeCheck   = 3'd1,
    CfgTypeValue   = 3'd2,
    CfgHandleCheck = 3'd3,
    CfgHandleValue = 3'd4,
    CfgMatchIndex  = 3'd5,
    CfgTableBytes  = 3'd6,
    CfgStructLimit = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        report_all;
    logic        type_check;
    logic [7:0]  type_value;
    logic        handle_check;
    logic [15:0] handle_value;
    logic [15:0] match_index;
    logic [15:0] table_bytes;
    logic [15:0] structure_limit;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] offset;
    logic [7:0]  etype;
    logic [7:0]  elength;
    logic [15:0] handle;
    logic [15:0] number;
    logic        found;
    logic        last;
  } result_t;

  // Results produced by one table byte: slot b is only used when slot a is.
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t res_a;
    result_t res_b;
  } push_t;

  typedef struct packed {
    logic fire;
    logic stopped;
  } walk_stat_t;

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == Max16) ? v : v + 16'd1;
  endfunction

endpackage

>>> hdl/smbios_structure_table_matcher_top.sv
// ---------------------------------------------------------------------------
// SMBIOS structure table matcher
// Walks an SMBIOS structure table byte by byte and reports matching entries.
// ---------------------------------------------------------------------------
// Table bytes arrive on the input request channel (in_valid_i / in_ready_o);
// table_start_i marks byte 0 of a walk and abandons any walk in progress.
// Results leave on the output request channel (out_valid_o / out_ready_i):
// match reports, then one finish result with last_o set.
// Configuration must be written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// only while no walk is in progress; the block does not enforce this.
// Each byte is registered, then walked and its results written to a small
// result queue, from which they are offered in order: a finish that follows
// a match report from the same byte is offered after that report. One byte
// is accepted per cycle while the queue has room for two results, which a
// receiver that keeps up always leaves. When the receiver stalls, the queue
// fills and in_ready_o falls; nothing is lost. After reset the walker is
// idle until a byte with table_start_i, the configuration registers are
// zero and the queue is empty.
// ---------------------------------------------------------------------------
`include "smbios_structure_table_matcher_top_assert.svh"

module smbios_structure_table_matcher_top #(
  parameter int unsigned OutDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        table_start_i,
  input  logic [7:0]  table_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [15:0] entry_offset_o,
  output logic [7:0]  entry_type_o,
  output logic [7:0]  entry_length_o,
  output logic [15:0] entry_handle_o,
  output logic [15:0] match_number_o,
  output logic        found_any_o,
  output logic        last_o
);

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  smbios_stm_pkg::cfg_t       cfg;
  smbios_stm_pkg::push_t      push;
  smbios_stm_pkg::walk_stat_t stat;
  smbios_stm_pkg::result_t    res;
  logic                       room;
  logic [CntW-1:0]            q_count;

  smbios_stm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  smbios_stm_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .table_start_i (table_start_i),
    .table_byte_i  (table_byte_i),
    .room_i        (room),
    .push_o        (push),
    .stat_o        (stat)
  );

  smbios_stm_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res),
    .count_o     (q_count)
  );

  assign result_kind_o  = res.kind;
  assign entry_offset_o = res.offset;
  assign entry_type_o   = res.etype;
  assign entry_length_o = res.elength;
  assign entry_handle_o = res.handle;
  assign match_number_o = res.number;
  assign found_any_o    = res.found;
  assign last_o         = res.last;

  `SMBIOS_STM_ASSERT_SAME(a_queue_bound, clk_i, rst_ni, 1'b1,
    q_count <= CntW'(OutDepth), "result queue holds more than its depth")
  `SMBIOS_STM_ASSERT_SAME(a_second_is_finish, clk_i, rst_ni, push.push_b,
    push.push_a && push.res_b.last && push.res_b.kind, "second result is not a finish")
  `SMBIOS_STM_ASSERT_NEXT(a_finish_stops, clk_i, rst_ni,
    (push.push_a && push.res_a.last) || push.push_b, stat.stopped,
    "walk still running after its finish result")
  `SMBIOS_STM_ASSERT_SAME(a_ready_with_room, clk_i, rst_ni, room, in_ready_o,
    "input stalled although the result queue has room")

endmodule

>>> hdl/smbios_stm_cfg.sv
// ---------------------------------------------------------------------------
// SMBIOS structure table matcher configuration registers
// Write-only register file, one register written per enabled cycle.
// ---------------------------------------------------------------------------
module smbios_stm_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [smbios_stm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [smbios_stm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output smbios_stm_pkg::cfg_t                 cfg_o
);

  smbios_stm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (smbios_stm_pkg::cfg_idx_e'(cfg_idx_i))
        smbios_stm_pkg::CfgReportAll:   cfg_d.report_all      = cfg_wdata_i[0];
        smbios_stm_pkg::CfgTypeCheck:   cfg_d.type_check      = cfg_wdata_i[0];
        smbios_stm_pkg::CfgTypeValue:   cfg_d.type_value      = cfg_wdata_i[7:0];
        smbios_stm_pkg::CfgHandleCheck: cfg_d.handle_check    = cfg_wdata_i[0];
        smbios_stm_pkg::CfgHandleValue: cfg_d.handle_value    = cfg_wdata_i[15:0];
        smbios_stm_pkg::CfgMatchIndex:  cfg_d.match_index     = cfg_wdata_i[15:0];
        smbios_stm_pkg::CfgTableBytes:  cfg_d.table_bytes     = cfg_wdata_i[15:0];
        smbios_stm_pkg::CfgStructLimit: cfg_d.structure_limit = cfg_wdata_i[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/smbios_stm_walk.sv
// ---------------------------------------------------------------------------
// SMBIOS structure table matcher walker
// Input byte register followed by the per-byte structure walk and match.
// ---------------------------------------------------------------------------
module smbios_stm_walk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smbios_stm_pkg::cfg_t       cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       table_start_i,
  input  logic [7:0]                 table_byte_i,
  input  logic                       room_i,
  output smbios_stm_pkg::push_t      push_o,
  output smbios_stm_pkg::walk_stat_t stat_o
);

  logic        in_valid_q;
  logic        in_start_q;
  logic [7:0]  in_byte_q;
  logic        fire;

  logic [15:0] pos_q, pos_d, estart_q, estart_d, seen_q, seen_d, mcount_q, mcount_d;
  logic [7:0]  off_q, off_d, ctype_q, ctype_d, clen_q, clen_d;
  logic [15:0] chandle_q, chandle_d;
  logic        instr_q, instr_d, pz_q, pz_d, stopped_q, stopped_d, rep_q, rep_d;
  smbios_stm_pkg::push_t push;

  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    logic                    done;
    logic                    hit;
    smbios_stm_pkg::result_t fin;
    done      = 1'b0;
    hit       = 1'b0;
    pos_d     = pos_q;
    estart_d  = estart_q;
    seen_d    = seen_q;
    mcount_d  = mcount_q;
    off_d     = off_q;
    ctype_d   = ctype_q;
    clen_d    = clen_q;
    chandle_d = chandle_q;
    instr_d   = instr_q;
    pz_d      = pz_q;
    stopped_d = stopped_q;
    rep_d     = rep_q;
    push      = '0;
    fin       = '0;

    if (in_start_q) begin
      pos_d     = '0;
      estart_d  = '0;
      seen_d    = '0;
      mcount_d  = '0;
      off_d     = '0;
      ctype_d   = '0;
      clen_d    = '0;
      chandle_d = '0;
      instr_d   = 1'b0;
      pz_d      = 1'b0;
      rep_d     = 1'b0;
      stopped_d = 1'b0;
      if (!((cfg_i.table_bytes != 16'd0) && (cfg_i.structure_limit != 16'd0))) begin
        fin.kind     = 1'b1;
        fin.last     = 1'b1;
        push.push_a  = 1'b1;
        push.res_a   = fin;
        stopped_d    = 1'b1;
        done         = 1'b1;
      end
    end

    if (!done && !stopped_d) begin
      pos_d = smbios_stm_pkg::sat_inc16(pos_d);
      if (!instr_d) begin
        case (off_d)
          8'd0: ctype_d = in_byte_q;
          8'd1: clen_d  = (in_byte_q < smbios_stm_pkg::MinLen) ?
                          smbios_stm_pkg::MinLen : in_byte_q;
          8'd2: chandle_d = {8'd0, in_byte_q};
          8'd3: begin
            chandle_d = {in_byte_q, chandle_d[7:0]};
            hit = (!cfg_i.type_check || (ctype_d == cfg_i.type_value)) &&
                  (!cfg_i.handle_check || (chandle_d == cfg_i.handle_value));
          end
          default: ctype_d = ctype_d;
        endcase
        if (hit) begin
          mcount_d = smbios_stm_pkg::sat_inc16(mcount_d);
          if ((cfg_i.match_index == 16'd0) || (mcount_d == cfg_i.match_index)) begin
            push.push_a         = 1'b1;
            push.res_a.kind     = 1'b0;
            push.res_a.offset   = estart_d;
            push.res_a.etype    = ctype_d;
            push.res_a.elength  = clen_d;
            push.res_a.handle   = chandle_d;
            push.res_a.number   = mcount_d;
            push.res_a.found    = 1'b0;
            push.res_a.last     = 1'b0;
            rep_d               = 1'b1;
            if (!(cfg_i.report_all && (cfg_i.match_index == 16'd0))) begin
              fin.kind    = 1'b1;
              fin.last    = 1'b1;
              fin.number  = mcount_d;
              fin.found   = 1'b1;
              push.push_b = 1'b1;
              push.res_b  = fin;
              stopped_d   = 1'b1;
              done        = 1'b1;
            end
          end
        end
        if (!done) begin
          if ((off_d >= 8'd3) && (({1'b0, off_d} + 9'd1) >= {1'b0, clen_d})) begin
            instr_d = 1'b1;
            pz_d    = 1'b0;
          end else begin
            off_d = off_d + 8'd1;
          end
        end
      end else if ((in_byte_q == 8'd0) && pz_d) begin
        // Double zero closes the string list: next structure or end of walk.
        seen_d    = smbios_stm_pkg::sat_inc16(seen_d);
        estart_d  = pos_d;
        off_d     = '0;
        ctype_d   = '0;
        clen_d    = '0;
        chandle_d = '0;
        instr_d   = 1'b0;
        pz_d      = 1'b0;
        if (!((pos_d < cfg_i.table_bytes) && (seen_d < cfg_i.structure_limit))) begin
          fin.kind    = 1'b1;
          fin.last    = 1'b1;
          fin.number  = mcount_d;
          fin.found   = rep_d;
          push.push_a = 1'b1;
          push.res_a  = fin;
          stopped_d   = 1'b1;
        end
      end else begin
        pz_d = (in_byte_q == 8'd0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_start_q <= table_start_i;
      in_byte_q  <= table_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pos_q      <= '0;
      estart_q   <= '0;
      seen_q     <= '0;
      mcount_q   <= '0;
      off_q      <= '0;
      ctype_q    <= '0;
      clen_q     <= '0;
      chandle_q  <= '0;
      instr_q    <= 1'b0;
      pz_q       <= 1'b0;
      stopped_q  <= 1'b1;
      rep_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        pos_q     <= pos_d;
        estart_q  <= estart_d;
        seen_q    <= seen_d;
        mcount_q  <= mcount_d;
        off_q     <= off_d;
        ctype_q   <= ctype_d;
        clen_q    <= clen_d;
        chandle_q <= chandle_d;
        instr_q   <= instr_d;
        pz_q      <= pz_d;
        stopped_q <= stopped_d;
        rep_q     <= rep_d;
      end
    end
  end

  always_comb begin
    push_o        = push;
    push_o.push_a = push.push_a && fire;
    push_o.push_b = push.push_b && fire;
  end

  assign stat_o.fire    = fire;
  assign stat_o.stopped = stopped_q;

endmodule

>>> hdl/smbios_stm_outq.sv
// ---------------------------------------------------------------------------
// SMBIOS structure table matcher result queue
// Small register queue taking up to two results per cycle, one out per cycle.
// ---------------------------------------------------------------------------
module smbios_stm_outq #(
  parameter int unsigned Depth = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smbios_stm_pkg::push_t   push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output smbios_stm_pkg::result_t out_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  smbios_stm_pkg::result_t slots_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d, wp_b;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = slots_q[rp_q];
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign count_o     = cnt_q;
  assign wp_b        = ptr_inc(wp_q);

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i.push_a) begin
      wp_d = wp_b;
      if (push_i.push_b) begin
        wp_d = ptr_inc(wp_b);
      end
    end
    if (pop) begin
      rp_d = ptr_inc(rp_q);
    end
    cnt_d = cnt_q + CntW'(push_i.push_a) + CntW'(push_i.push_b) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      slots_q[wp_q] <= push_i.res_a;
    end
    if (push_i.push_b) begin
      slots_q[wp_b] <= push_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
